@@ rtl/ket_pkg.sv @@
// ----------------------------------------------------------------------------
// ket_pkg
// Shared types, constants and codes for the keyed entry table with sweep.
// ----------------------------------------------------------------------------
package ket_pkg;

   localparam int SLOTS         = 16;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int SLOT_BITS     = $clog2(SLOTS);
   localparam int COUNT_BITS    = $clog2(SLOTS + 1);

   localparam logic [2:0] CMD_ADD      = 3'd0;
   localparam logic [2:0] CMD_REMOVE   = 3'd1;
   localparam logic [2:0] CMD_READ_POS = 3'd2;
   localparam logic [2:0] CMD_READ_KEY = 3'd3;
   localparam logic [2:0] CMD_SET_STAT = 3'd4;

   localparam logic [2:0] RES_OK        = 3'd0;
   localparam logic [2:0] RES_NOT_FOUND = 3'd1;
   localparam logic [2:0] RES_NO_SLOT   = 3'd2;
   localparam logic [2:0] RES_BAD_POS   = 3'd3;
   localparam logic [2:0] RES_NEAR_LIM  = 3'd4;

   localparam logic CSR_SWEEP_LEVEL   = 1'b0;
   localparam logic CSR_FINISHED_MASK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ADD,
      ST_SWEEP,
      ST_SHIFT,
      ST_DONE
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan_step;
      logic add_write;
      logic sweep_step;
      logic sweep_end;
      logic unlink;
      logic shift_step;
      logic set_status;
      logic rsp_fire;
   } ctrl_type;

   // Datapath to controller status.
   typedef struct packed {
      logic [2:0] cmd;
      logic       scan_last;
      logic       hit;
      logic       full;
      logic       sweep_now;
      logic       sweep_last;
      logic       shift_last;
   } stat_type;

endpackage

@@ rtl/keyed_entry_table_with_sweep.sv @@
// ----------------------------------------------------------------------------
// keyed_entry_table_with_sweep
// Fixed slot pool holding keyed entries in newest-first order, with sweep.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// req_*     in         start and not busy
// rsp_*     out        rsp_valid strobe, one cycle
// csr_*     in         csr_valid and csr_ready
//
// Busy covers the key scan over each list entry it visits (at least one), the add
// step for an add, a step for each entry swept or shifted, and the done state.
// The response strobe follows the done state; an add that sweeps a full list is the
// longest request, and a new request is taken only once busy has dropped.
// Reset clears all valid bits and the count at once; no clearing pass.
// The receiver cannot stall responses.
module keyed_entry_table_with_sweep (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [15:0] req_entry_key,
   input  logic [3:0]  req_list_position,
   input  logic [2:0]  req_entry_status,
   input  logic [31:0] req_entry_payload,
   output logic        rsp_valid,
   output logic [2:0]  rsp_result_code,
   output logic [15:0] rsp_found_key,
   output logic [2:0]  rsp_found_status,
   output logic [31:0] rsp_found_payload,
   output logic [4:0]  rsp_count_now,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   ket_pkg::ctrl_type ctrl;
   ket_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ket_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   ket_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .stat              (stat),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_cmd           (req_cmd),
      .req_entry_key     (req_entry_key),
      .req_list_position (req_list_position),
      .req_entry_status  (req_entry_status),
      .req_entry_payload (req_entry_payload),
      .rsp_valid         (rsp_valid),
      .rsp_result_code   (rsp_result_code),
      .rsp_found_key     (rsp_found_key),
      .rsp_found_status  (rsp_found_status),
      .rsp_found_payload (rsp_found_payload),
      .rsp_count_now     (rsp_count_now)
   );

endmodule

@@ rtl/ket_ctrl.sv @@
// ----------------------------------------------------------------------------
// ket_ctrl
// Command sequencer for the keyed entry table.
// ----------------------------------------------------------------------------
module ket_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ket_pkg::stat_type  stat,
   output ket_pkg::ctrl_type  ctrl
);

   ket_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ket_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      busy     = (state_ff != ket_pkg::ST_IDLE);
      unique case (state_ff)
         ket_pkg::ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = ket_pkg::ST_SCAN;
            end
         end
         ket_pkg::ST_SCAN: begin
            if (stat.cmd == ket_pkg::CMD_ADD) begin
               if (stat.full) begin
                  state_in = ket_pkg::ST_DONE;
               end else begin
                  state_in = ket_pkg::ST_ADD;
               end
            end else if (stat.cmd inside {ket_pkg::CMD_REMOVE, ket_pkg::CMD_READ_KEY,
                                          ket_pkg::CMD_SET_STAT}) begin
               if (stat.hit) begin
                  if (stat.cmd == ket_pkg::CMD_REMOVE) begin
                     ctrl.unlink = 1'b1;
                     state_in    = ket_pkg::ST_SHIFT;
                  end else begin
                     ctrl.set_status = (stat.cmd == ket_pkg::CMD_SET_STAT);
                     state_in        = ket_pkg::ST_DONE;
                  end
               end else if (stat.scan_last) begin
                  state_in = ket_pkg::ST_DONE;
               end else begin
                  ctrl.scan_step = 1'b1;
               end
            end else begin
               state_in = ket_pkg::ST_DONE;
            end
         end
         ket_pkg::ST_ADD: begin
            ctrl.add_write = 1'b1;
            if (stat.sweep_now) begin
               ctrl.scan_clear = 1'b1;
               state_in        = ket_pkg::ST_SWEEP;
            end else begin
               state_in = ket_pkg::ST_DONE;
            end
         end
         ket_pkg::ST_SWEEP: begin
            ctrl.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               ctrl.sweep_end = 1'b1;
               state_in       = ket_pkg::ST_DONE;
            end
         end
         ket_pkg::ST_SHIFT: begin
            ctrl.shift_step = 1'b1;
            if (stat.shift_last) begin
               state_in = ket_pkg::ST_DONE;
            end
         end
         ket_pkg::ST_DONE: begin
            ctrl.rsp_fire = 1'b1;
            state_in      = ket_pkg::ST_IDLE;
         end
         default: state_in = ket_pkg::ST_IDLE;
      endcase
   end

   a_done_from_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == ket_pkg::ST_DONE |-> $past(state_ff) != ket_pkg::ST_IDLE)
      else $error("response without a request");
   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == ket_pkg::ST_SCAN)
      else $error("request not taken");
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ket_pkg::ST_DONE |=> state_ff == ket_pkg::ST_IDLE)
      else $error("done did not return to idle");

endmodule

@@ rtl/ket_datapath.sv @@
// ----------------------------------------------------------------------------
// ket_datapath
// Slot pool, newest-first order list, scan pointer and response registers.
// ----------------------------------------------------------------------------
module ket_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ket_pkg::ctrl_type                     ctrl,
   output ket_pkg::stat_type                     stat,
   input  logic                                  csr_valid,
   input  logic                                  csr_index,
   input  logic [7:0]                            csr_data,
   input  logic [2:0]                            req_cmd,
   input  logic [15:0]                           req_entry_key,
   input  logic [3:0]                            req_list_position,
   input  logic [2:0]                            req_entry_status,
   input  logic [31:0]                           req_entry_payload,
   output logic                                  rsp_valid,
   output logic [2:0]                            rsp_result_code,
   output logic [15:0]                           rsp_found_key,
   output logic [2:0]                            rsp_found_status,
   output logic [31:0]                           rsp_found_payload,
   output logic [4:0]                            rsp_count_now
);

   localparam int SB = ket_pkg::SLOT_BITS;
   localparam int CB = ket_pkg::COUNT_BITS;
   localparam int PW = ket_pkg::PAYLOAD_WIDTH;

   logic [ket_pkg::SLOTS-1:0] valid_ff, valid_in;
   logic [15:0]               key_ff     [ket_pkg::SLOTS];
   logic [2:0]                status_ff  [ket_pkg::SLOTS];
   logic [PW-1:0]             payload_ff [ket_pkg::SLOTS];
   logic [SB-1:0]             order_ff   [ket_pkg::SLOTS];
   logic [CB-1:0]             count_ff, count_in;
   logic [4:0]                level_ff;
   logic [7:0]                mask_ff;

   logic [2:0]    cmd_ff;
   logic [15:0]   key_q_ff;
   logic [3:0]    pos_ff;
   logic [2:0]    st_q_ff;
   logic [PW-1:0] pay_q_ff;
   logic [CB-1:0] ptr_ff, ptr_in;
   logic [CB-1:0] wr_ff, wr_in;
   logic          any_ff, any_in;
   logic [2:0]    code_ff;

   logic [SB-1:0] ptr_idx, free_slot, cur_slot;
   logic          have_free, ptr_inside, sweep_hit;
   logic [CB:0]   count_plus;

   assign ptr_idx    = ptr_ff[SB-1:0];
   assign ptr_inside = (ptr_ff < count_ff);
   assign cur_slot   = order_ff[ptr_idx];
   assign count_plus = {1'b0, count_ff} + 1'b1;
   assign sweep_hit  = mask_ff[status_ff[cur_slot]];

   always_comb begin
      have_free = 1'b0;
      free_slot = '0;
      for (int i = ket_pkg::SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            have_free = 1'b1;
            free_slot = SB'(i);
         end
      end
   end

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.full       = !have_free || (count_ff >= CB'(ket_pkg::SLOTS));
      stat.hit        = ptr_inside && (key_ff[cur_slot] == key_q_ff);
      stat.scan_last  = (ptr_ff + 1'b1 >= count_ff) || !ptr_inside;
      stat.sweep_now  = (count_plus >= {1'b0, level_ff});
      stat.sweep_last = (ptr_ff + 1'b1 >= count_ff);
      stat.shift_last = (ptr_ff + 2'd2 >= count_ff);
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      wr_in    = wr_ff;
      any_in   = any_ff;
      if (ctrl.load) begin
         ptr_in = '0;
      end
      if (ctrl.scan_step) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (ctrl.add_write) begin
         valid_in[free_slot] = 1'b1;
         count_in            = count_plus[CB-1:0];
      end
      if (ctrl.scan_clear) begin
         ptr_in = '0;
         wr_in  = '0;
         any_in = 1'b0;
      end
      if (ctrl.sweep_step) begin
         ptr_in = ptr_ff + 1'b1;
         if (sweep_hit) begin
            valid_in[cur_slot] = 1'b0;
            any_in             = 1'b1;
         end else begin
            wr_in = wr_ff + 1'b1;
         end
         if (ctrl.sweep_end) begin
            count_in = sweep_hit ? wr_ff : wr_ff + 1'b1;
         end
      end
      if (ctrl.unlink) begin
         valid_in[cur_slot] = 1'b0;
      end
      if (ctrl.shift_step) begin
         ptr_in = ptr_ff + 1'b1;
         if (stat.shift_last) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         count_ff  <= '0;
         level_ff  <= 5'd16;
         mask_ff   <= 8'd224;
         rsp_valid <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         count_ff  <= count_in;
         rsp_valid <= ctrl.rsp_fire;
         if (csr_valid) begin
            if (csr_index == ket_pkg::CSR_SWEEP_LEVEL) begin
               level_ff <= csr_data[4:0];
            end else begin
               mask_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      wr_ff  <= wr_in;
      any_ff <= any_in;
      if (ctrl.load) begin
         cmd_ff   <= req_cmd;
         key_q_ff <= req_entry_key;
         pos_ff   <= req_list_position;
         st_q_ff  <= req_entry_status;
         pay_q_ff <= req_entry_payload[PW-1:0];
      end
      if (ctrl.add_write) begin
         key_ff[free_slot]     <= key_q_ff;
         status_ff[free_slot]  <= st_q_ff;
         payload_ff[free_slot] <= pay_q_ff;
         for (int i = 1; i < ket_pkg::SLOTS; i++) begin
            order_ff[i] <= order_ff[i-1];
         end
         order_ff[0] <= free_slot;
      end
      if (ctrl.sweep_step && !sweep_hit) begin
         order_ff[wr_ff[SB-1:0]] <= cur_slot;
      end
      if (ctrl.shift_step && ptr_ff + 1'b1 < CB'(ket_pkg::SLOTS)) begin
         order_ff[ptr_idx] <= order_ff[SB'(ptr_ff + 1'b1)];
      end
      if (ctrl.set_status) begin
         status_ff[cur_slot] <= st_q_ff;
      end
   end

   // Response formation.
   logic [CB-1:0] pos_ext;
   logic [SB-1:0] pos_slot;
   assign pos_ext  = CB'(pos_ff);
   assign pos_slot = order_ff[pos_ff[SB-1:0]];

   always_ff @(posedge clock) begin
      if (ctrl.rsp_fire) begin
         rsp_result_code   <= ket_pkg::RES_OK;
         rsp_found_key     <= '0;
         rsp_found_status  <= '0;
         rsp_found_payload <= '0;
         rsp_count_now     <= 5'(count_ff);
         case (cmd_ff) inside
            ket_pkg::CMD_ADD: begin
               if (code_ff == ket_pkg::RES_NO_SLOT) begin
                  rsp_result_code <= ket_pkg::RES_NO_SLOT;
               end else if (code_ff == ket_pkg::RES_NEAR_LIM) begin
                  rsp_result_code <= any_ff ? ket_pkg::RES_OK : ket_pkg::RES_NEAR_LIM;
               end
            end
            ket_pkg::CMD_READ_POS: begin
               if (pos_ext >= count_ff) begin
                  rsp_result_code <= ket_pkg::RES_BAD_POS;
               end else begin
                  rsp_found_key     <= key_ff[pos_slot];
                  rsp_found_status  <= status_ff[pos_slot];
                  rsp_found_payload <= 32'(payload_ff[pos_slot]);
               end
            end
            ket_pkg::CMD_REMOVE, ket_pkg::CMD_SET_STAT: begin
               rsp_result_code <= code_ff;
            end
            ket_pkg::CMD_READ_KEY: begin
               rsp_result_code <= code_ff;
               if (code_ff == ket_pkg::RES_OK) begin
                  rsp_found_key     <= key_ff[cur_slot];
                  rsp_found_status  <= status_ff[cur_slot];
                  rsp_found_payload <= 32'(payload_ff[cur_slot]);
               end
            end
            default: ;
         endcase
      end
   end

   // Outcome code captured during the command.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         code_ff <= ket_pkg::RES_NOT_FOUND;
      end else if (stat.hit && !ctrl.sweep_step && !ctrl.shift_step &&
                   cmd_ff != ket_pkg::CMD_ADD && code_ff == ket_pkg::RES_NOT_FOUND) begin
         code_ff <= ket_pkg::RES_OK;
      end else if (cmd_ff == ket_pkg::CMD_ADD && code_ff == ket_pkg::RES_NOT_FOUND) begin
         code_ff <= stat.full ? ket_pkg::RES_NO_SLOT : ket_pkg::RES_OK;
      end else if (ctrl.add_write && stat.sweep_now) begin
         code_ff <= ket_pkg::RES_NEAR_LIM;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(ket_pkg::SLOTS))
      else $error("entry count above pool size");
   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_fire |-> $countones(valid_ff) == int'(count_ff))
      else $error("valid slots disagree with count");
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.add_write |=> count_ff == $past(count_ff) + 1'b1)
      else $error("add did not grow count");

endmodule
